// ===== hdl/duplex_sponge_aead_engine_unit_macros.svh =====
// Assertion macros for the sponge AEAD engine checker
`ifndef DUPLEX_SPONGE_AEAD_ENGINE_UNIT_MACROS_SVH
`define DUPLEX_SPONGE_AEAD_ENGINE_UNIT_MACROS_SVH
// implication checked on every edge outside reset
`define DSAE_ASSERT_IMP(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication checked outside reset
`define DSAE_ASSERT_NXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== hdl/dsae_pkg.sv =====
`timescale 1ns / 1ps
package dsae_pkg;
	localparam int unsigned ROUNDS = 4;
	localparam int unsigned RND_W = $clog2(ROUNDS * 8 + 1);

	localparam logic [2:0] ACT_INIT = 3'd0;
	localparam logic [2:0] ACT_ABSORB = 3'd1;
	localparam logic [2:0] ACT_ENC = 3'd2;
	localparam logic [2:0] ACT_DEC = 3'd3;
	localparam logic [2:0] ACT_FIN = 3'd4;
	localparam logic [2:0] ACT_VERIFY = 3'd5;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_TAG = 2'd1;
	localparam logic [1:0] KIND_VERIFY = 2'd2;

	localparam logic [2:0] REG_ABS_TAG = 3'd4;
	localparam logic [2:0] REG_ENC_TAG = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PERM, ST_APPLY, ST_INJECT, ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture input item
		logic step;      // one column or diagonal step
		logic apply;     // apply word op to state
		logic inject;    // xor lengths
		logic tag_out;   // present tag word
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic        perm_first;   // item needs permutation before apply
		logic        is_fin;
		logic        has_out;      // apply gives a result
		logic        ignore;
	} sts_t;

	function automatic logic [63:0] byte_mask(input logic [3:0] n);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) if (n > 4'(i)) m[i*8 +: 8] = 8'hFF;
		return m;
	endfunction

	function automatic logic [63:0] rotr(input logic [63:0] x, input int c);
		return (x >> c) | (x << (64 - c));
	endfunction

	// one G function on four words
	function automatic logic [255:0] gmix(input logic [63:0] a, b, c, d);
		logic [63:0] ta, tb, tc, td;
		ta = a + b; td = rotr(d ^ ta, 32);
		tc = c + td; tb = rotr(b ^ tc, 24);
		ta = ta + tb; td = rotr(td ^ ta, 16);
		tc = tc + td; tb = rotr(tb ^ tc, 63);
		return {ta, tb, tc, td};
	endfunction
endpackage

// ===== hdl/dsae_datapath.sv =====
`timescale 1ns / 1ps
module dsae_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dsae_pkg::cmd_t        cmd,
	output dsae_pkg::sts_t        sts,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_idx,
	input  logic [63:0]           cfg_data,
	input  logic [2:0]            action,
	input  logic [63:0]           data_in,
	input  logic [3:0]            byte_count,
	input  logic                  ends_segment,
	input  logic                  domain,
	input  logic [63:0]           header_bytes,
	input  logic [63:0]           message_bytes,
	input  logic [1:0]            tag_sel,
	output logic [63:0]           word_out,
	output logic [1:0]            out_kind,
	output logic                  tag_match
);
	import dsae_pkg::*;

	logic [63:0] st_q [16];
	logic [63:0] key_q [4];
	logic [7:0] abs_tag_q, enc_tag_q;
	logic [3:0] pos_q;
	logic mism_q;
	logic diag_q;
	logic [2:0] act_q;
	logic [63:0] data_q, mask_q, hdr_q, msg_q;
	logic ends_q, dom_q;
	logic [3:0] ipos;
	logic [63:0] res_q;
	logic [1:0] kind_q;
	logic match_q;
	logic [63:0] nx [16];
	logic [3:0] ep;

	// effective position for encrypt and decrypt
	always_comb begin
		ipos = pos_q;
		if ((action == ACT_ENC || action == ACT_DEC) && pos_q >= 4'd12) ipos = '0;
		sts.perm_first = ((action == ACT_ABSORB || action == ACT_ENC
			|| action == ACT_DEC) && ipos == '0) || action == ACT_FIN;
		sts.is_fin = act_q == ACT_FIN;
		sts.has_out = act_q == ACT_ENC || act_q == ACT_DEC
			|| (act_q == ACT_VERIFY && ends_q);
		sts.ignore = action > ACT_VERIFY;
	end

	// column or diagonal step
	always_comb begin
		logic [255:0] g0, g1, g2, g3;
		for (int i = 0; i < 16; i++) nx[i] = st_q[i];
		if (!diag_q) begin
			g0 = gmix(st_q[0], st_q[4], st_q[8], st_q[12]);
			g1 = gmix(st_q[1], st_q[5], st_q[9], st_q[13]);
			g2 = gmix(st_q[2], st_q[6], st_q[10], st_q[14]);
			g3 = gmix(st_q[3], st_q[7], st_q[11], st_q[15]);
			{nx[0], nx[4], nx[8], nx[12]} = g0;
			{nx[1], nx[5], nx[9], nx[13]} = g1;
			{nx[2], nx[6], nx[10], nx[14]} = g2;
			{nx[3], nx[7], nx[11], nx[15]} = g3;
		end else begin
			g0 = gmix(st_q[0], st_q[5], st_q[10], st_q[15]);
			g1 = gmix(st_q[1], st_q[6], st_q[11], st_q[12]);
			g2 = gmix(st_q[2], st_q[7], st_q[8], st_q[13]);
			g3 = gmix(st_q[3], st_q[4], st_q[9], st_q[14]);
			{nx[0], nx[5], nx[10], nx[15]} = g0;
			{nx[1], nx[6], nx[11], nx[12]} = g1;
			{nx[2], nx[7], nx[8], nx[13]} = g2;
			{nx[3], nx[4], nx[9], nx[14]} = g3;
		end
	end

	assign ep = pos_q;

	// hold payload of the item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			mask_q <= byte_mask(byte_count);
			data_q <= data_in & byte_mask(byte_count);
			hdr_q <= header_bytes;
			msg_q <= message_bytes;
			ends_q <= ends_segment;
			dom_q <= domain;
		end
	end

	// state, config and position registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) st_q[i] <= '0;
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			abs_tag_q <= '0;
			enc_tag_q <= '0;
			pos_q <= '0;
			mism_q <= 1'b0;
			diag_q <= 1'b0;
			res_q <= '0;
			kind_q <= KIND_DATA;
			match_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx < 3'd4) key_q[cfg_idx[1:0]] <= cfg_data;
				else if (cfg_idx == REG_ABS_TAG) abs_tag_q <= cfg_data[7:0];
				else if (cfg_idx == REG_ENC_TAG) enc_tag_q <= cfg_data[7:0];
			end
			if (cmd.load) begin
				pos_q <= ipos;
				diag_q <= 1'b0;
			end
			if (cmd.step) begin
				for (int i = 0; i < 16; i++) st_q[i] <= nx[i];
				diag_q <= !diag_q;
			end
			if (cmd.inject) begin
				st_q[0] <= st_q[0] ^ hdr_q;
				st_q[1] <= st_q[1] ^ msg_q;
				diag_q <= 1'b0;
			end
			if (cmd.tag_out) begin
				res_q <= st_q[tag_sel];
				kind_q <= KIND_TAG;
				match_q <= 1'b0;
			end
			if (cmd.apply) begin
				case (act_q)
					ACT_INIT: begin
						if (ep == '0) begin
							for (int i = 0; i < 9; i++) st_q[i] <= '0;
							st_q[9] <= 64'(ROUNDS);
							st_q[10] <= 64'd256;
							st_q[11] <= {56'd0, dom_q ? enc_tag_q : abs_tag_q};
							for (int i = 0; i < 4; i++) st_q[12 + i] <= key_q[i];
						end
						if (ep < 4'd9) st_q[ep] <= data_q;
						pos_q <= ends_q ? '0 : ep + 4'd1;
					end
					ACT_ABSORB: begin
						st_q[ep] <= st_q[ep] ^ data_q;
						pos_q <= ends_q ? '0 : ep + 4'd1;
					end
					ACT_ENC, ACT_DEC: begin
						if (act_q == ACT_ENC) begin
							st_q[ep] <= st_q[ep] ^ data_q;
							res_q <= (st_q[ep] ^ data_q) & mask_q;
						end else begin
							st_q[ep] <= data_q | (st_q[ep] & ~mask_q);
							res_q <= (st_q[ep] ^ data_q) & mask_q;
						end
						kind_q <= KIND_DATA;
						match_q <= 1'b0;
						pos_q <= (ends_q || ep >= 4'd11) ? '0 : ep + 4'd1;
					end
					ACT_FIN: pos_q <= '0;
					ACT_VERIFY: begin
						if (ends_q) begin
							res_q <= '0;
							kind_q <= KIND_VERIFY;
							match_q <= !(((ep == '0) ? 1'b0 : mism_q)
								|| data_q != (st_q[ep] & mask_q));
							mism_q <= 1'b0;
						end else begin
							mism_q <= ((ep == '0) ? 1'b0 : mism_q)
								|| data_q != (st_q[ep] & mask_q);
						end
						pos_q <= ends_q ? '0 : ep + 4'd1;
					end
					default: ;
				endcase
			end
		end
	end

	assign word_out = res_q;
	assign out_kind = kind_q;
	assign tag_match = match_q;
endmodule

// ===== hdl/dsae_ctrl.sv =====
`timescale 1ns / 1ps
module dsae_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            last,
	output logic [1:0]      tag_sel,
	output dsae_pkg::cmd_t  cmd,
	input  dsae_pkg::sts_t  sts
);
	import dsae_pkg::*;

	state_t st_q, st_d;
	logic [RND_W-1:0] cnt_q;
	logic second_q;
	logic [1:0] tsel_q;
	logic ov_q, last_q;
	logic perm_done;

	assign perm_done = cnt_q == RND_W'(ROUNDS * 2 - 1);
	assign in_ready = st_q == ST_IDLE && !ov_q;
	assign out_valid = ov_q;
	assign last = last_q;
	// select the word that the next tag load presents
	assign tag_sel = ov_q ? tsel_q + 2'd1 : tsel_q;

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (in_valid && in_ready && !sts.ignore)
				st_d = sts.perm_first ? ST_PERM : ST_APPLY;
			ST_PERM: if (perm_done) begin
				if (sts.is_fin) st_d = second_q ? ST_OUT : ST_INJECT;
				else st_d = ST_APPLY;
			end
			ST_INJECT: st_d = ST_PERM;
			ST_APPLY: st_d = ST_IDLE;
			ST_OUT: if (!ov_q || out_ready) begin
				if (tsel_q == 2'd3 && ov_q) st_d = ST_APPLY;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		cmd.load = st_q == ST_IDLE && in_valid && in_ready;
		cmd.step = st_q == ST_PERM;
		cmd.inject = st_q == ST_INJECT;
		cmd.apply = st_q == ST_APPLY;
		cmd.tag_out = st_q == ST_OUT && (!ov_q || out_ready)
			&& !(ov_q && tsel_q == 2'd3);
	end

	// sequencing registers and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			second_q <= 1'b0;
			tsel_q <= '0;
			ov_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_PERM) cnt_q <= perm_done ? '0 : cnt_q + RND_W'(1);
			if (cmd.load) begin
				second_q <= 1'b0;
				tsel_q <= '0;
			end
			if (st_q == ST_INJECT) second_q <= 1'b1;
			if (ov_q && out_ready) ov_q <= 1'b0;
			if (cmd.tag_out) begin
				ov_q <= 1'b1;
				if (ov_q) tsel_q <= tsel_q + 2'd1;
				last_q <= ov_q ? (tsel_q == 2'd2) : 1'b0;
			end
			if (cmd.apply && sts.has_out && !sts.is_fin) begin
				ov_q <= 1'b1;
				last_q <= 1'b1;
			end
		end
	end
endmodule

// ===== hdl/duplex_sponge_aead_engine_unit.sv =====
`timescale 1ns / 1ps
// Sponge AEAD engine on a 16-word 64-bit state (BLAKE2b G permutation).
// Input channel in_valid/in_ready takes one word item: action, data_in,
// byte_count, ends_segment, domain and for finalise the two lengths.
// Output channel out_valid/out_ready gives word_out, out_kind, tag_match
// and last. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_data): indexes 0..3 key words, 4 and 5 the domain tags.
// A word without block start goes through load and apply; a block start
// first runs the permutation in alternating column/diagonal G steps.
// Finalise runs two permutations with the lengths injected between, then
// issues four tag items, one per cycle while the receiver takes them.
// One item is in work at a time; results sit in an output register, and
// a stalled receiver holds the engine until the result is taken.
// Reset clears the state, key, tags and position at once.
module duplex_sponge_aead_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [63:0] data_in,
	input  logic [3:0]  byte_count,
	input  logic        ends_segment,
	input  logic        domain,
	input  logic [63:0] header_bytes,
	input  logic [63:0] message_bytes,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] word_out,
	output logic [1:0]  out_kind,
	output logic        tag_match,
	output logic        last,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import dsae_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [1:0] tag_sel;

	dsae_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.last, .tag_sel, .cmd, .sts
	);

	dsae_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .cfg_we, .cfg_idx(cfg_index),
		.cfg_data, .action, .data_in, .byte_count, .ends_segment, .domain,
		.header_bytes, .message_bytes, .tag_sel, .word_out, .out_kind,
		.tag_match
	);
endmodule

// ===== hdl/dsae_checker.sv =====
`timescale 1ns / 1ps
`include "duplex_sponge_aead_engine_unit_macros.svh"
module dsae_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_kind,
	input logic       tag_match,
	input logic       last
);
	import dsae_pkg::*;

	// no new item taken while a result waits
	`DSAE_ASSERT_IMP(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	// data and tag results never flag a match
	`DSAE_ASSERT_IMP(a_match_kind, clk, arst_n, out_valid && out_kind != KIND_VERIFY, !tag_match)
	// verify and data results are single
	`DSAE_ASSERT_IMP(a_single, clk, arst_n, out_valid && out_kind != KIND_TAG, last)
	// stalled result holds
	`DSAE_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_kind))
endmodule

bind duplex_sponge_aead_engine_unit dsae_checker u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
	.out_kind, .tag_match, .last
);

// ===== verif/duplex_sponge_aead_engine_unit_tb.sv =====
`timescale 1ns / 1ps
module duplex_sponge_aead_engine_unit_tb;
	import dsae_pkg::*;

	localparam int unsigned PERM_ROUNDS = 4;

	typedef struct {
		logic [63:0] word;
		logic [1:0]  kind;
		logic        match;
		logic        last;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  action = '0;
	logic [63:0] data_in = '0;
	logic [3:0]  byte_count = '0;
	logic        ends_segment = 1'b0;
	logic        domain = 1'b0;
	logic [63:0] header_bytes = '0;
	logic [63:0] message_bytes = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] word_out;
	logic [1:0]  out_kind;
	logic        tag_match;
	logic        last;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	// predictor copy of the engine
	logic [63:0] mdl_state [16];
	logic [3:0]  mdl_pos;
	logic        mdl_miss;
	logic [63:0] mdl_key [4];
	logic [7:0]  mdl_abs_tag;
	logic [7:0]  mdl_enc_tag;

	result_t     expected_results [$];
	int          errors = 0;
	int          items_sent = 0;
	int          results_seen = 0;
	bit          no_idle = 1'b0;

	duplex_sponge_aead_engine_unit u_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#50ms;
		$display("timeout at %0t", $time);
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic [63:0] rot_right(logic [63:0] x, int c);
		return (x >> c) | (x << (64 - c));
	endfunction

	function automatic logic [63:0] count_mask(logic [3:0] n);
		if (n >= 8) return '1;
		return (64'd1 << (8 * n)) - 64'd1;
	endfunction

	task automatic mix_words(int a, int b, int c, int d);
		mdl_state[a] = mdl_state[a] + mdl_state[b];
		mdl_state[d] = rot_right(mdl_state[d] ^ mdl_state[a], 32);
		mdl_state[c] = mdl_state[c] + mdl_state[d];
		mdl_state[b] = rot_right(mdl_state[b] ^ mdl_state[c], 24);
		mdl_state[a] = mdl_state[a] + mdl_state[b];
		mdl_state[d] = rot_right(mdl_state[d] ^ mdl_state[a], 16);
		mdl_state[c] = mdl_state[c] + mdl_state[d];
		mdl_state[b] = rot_right(mdl_state[b] ^ mdl_state[c], 63);
	endtask

	task automatic permute_state();
		for (int r = 0; r < PERM_ROUNDS; r++) begin
			mix_words(0, 4, 8, 12);
			mix_words(1, 5, 9, 13);
			mix_words(2, 6, 10, 14);
			mix_words(3, 7, 11, 15);
			mix_words(0, 5, 10, 15);
			mix_words(1, 6, 11, 12);
			mix_words(2, 7, 8, 13);
			mix_words(3, 4, 9, 14);
		end
	endtask

	task automatic push_result(logic [63:0] w, logic [1:0] k, logic m, logic l);
		result_t r;
		r.word = w; r.kind = k; r.match = m; r.last = l;
		expected_results.push_back(r);
	endtask

	// work out the results of one item and advance the copy
	task automatic predict_item(logic [2:0] act, logic [63:0] din, logic [3:0] bc,
			logic ends, logic dom, logic [63:0] hb, logic [63:0] mb);
		logic [63:0] mask, data, s;
		int p;
		mask = count_mask(bc);
		data = din & mask;
		p = mdl_pos;
		case (act)
			ACT_INIT: begin
				if (p == 0) begin
					foreach (mdl_state[i]) mdl_state[i] = '0;
					mdl_state[9] = PERM_ROUNDS;
					mdl_state[10] = 64'd256;
					mdl_state[11] = dom ? mdl_enc_tag : mdl_abs_tag;
					for (int i = 0; i < 4; i++) mdl_state[12 + i] = mdl_key[i];
				end
				if (p < 9) mdl_state[p] = data;
				p = (p + 1) & 15;
			end
			ACT_ABSORB: begin
				if (p == 0) permute_state();
				mdl_state[p] ^= data;
				p = (p + 1) & 15;
			end
			ACT_ENC, ACT_DEC: begin
				if (p >= 12) p = 0;
				if (p == 0) permute_state();
				if (act == ACT_ENC) begin
					mdl_state[p] ^= data;
					push_result(mdl_state[p] & mask, KIND_DATA, 1'b0, 1'b1);
				end else begin
					s = mdl_state[p];
					push_result((s ^ data) & mask, KIND_DATA, 1'b0, 1'b1);
					mdl_state[p] = data | (s & ~mask);
				end
				p = p + 1;
				if (p >= 12) p = 0;
			end
			ACT_FIN: begin
				permute_state();
				mdl_state[0] ^= hb;
				mdl_state[1] ^= mb;
				permute_state();
				for (int i = 0; i < 4; i++)
					push_result(mdl_state[i], KIND_TAG, 1'b0, i == 3);
				p = 0;
			end
			ACT_VERIFY: begin
				if (p == 0) mdl_miss = 1'b0;
				if (data != (mdl_state[p] & mask)) mdl_miss = 1'b1;
				if (ends) begin
					push_result('0, KIND_VERIFY, !mdl_miss, 1'b1);
					mdl_miss = 1'b0;
				end
				p = (p + 1) & 15;
			end
			default: return;
		endcase
		if (ends) p = 0;
		mdl_pos = p[3:0];
	endtask

	// send one item, holding it until accepted; drop valid only while idling
	task automatic send_item(logic [2:0] act, logic [63:0] din, logic [3:0] bc,
			logic ends, logic dom = 1'b0, logic [63:0] hb = '0, logic [63:0] mb = '0);
		while (!no_idle && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act; data_in <= din; byte_count <= bc;
		ends_segment <= ends; domain <= dom;
		header_bytes <= hb; message_bytes <= mb;
		predict_item(act, din, bc, ends, dom, hb, mb);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// wait until idle, then write one register
	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (4 * PERM_ROUNDS + 8) @(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx < 4) mdl_key[idx[1:0]] = val;
		else if (idx == REG_ABS_TAG) mdl_abs_tag = val[7:0];
		else if (idx == REG_ENC_TAG) mdl_enc_tag = val[7:0];
	endtask

	task automatic load_iv(logic dom, int words);
		for (int i = 0; i < words; i++)
			send_item(ACT_INIT, {$urandom, $urandom}, 4'd8, i == words - 1, dom);
	endtask

	// receiver stalls and result check
	always @(negedge clk)
		out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 16);

	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result word %h kind %0d", $time, word_out, out_kind);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (word_out !== e.word || out_kind !== e.kind ||
						tag_match !== e.match || last !== e.last) begin
					$display("%0t mismatch exp word %h kind %0d match %b last %b",
						$time, e.word, e.kind, e.match, e.last);
					$display("%0t          act word %h kind %0d match %b last %b",
						$time, word_out, out_kind, tag_match, last);
					errors++;
				end
			end
		end
	end

	task automatic test_registers();
		write_reg(3'd0, '1);
		write_reg(3'd1, 64'h0123_4567_89ab_cdef);
		write_reg(3'd2, '0);
		write_reg(3'd3, {$urandom, $urandom});
		write_reg(REG_ABS_TAG, 64'hff);
		write_reg(REG_ENC_TAG, 64'h00);
	endtask

	// directed: every action, byte count extremes, odd positions
	task automatic test_directed();
		logic [63:0] t [4];
		load_iv(1'b0, 9);
		send_item(ACT_ABSORB, '1, 4'd0, 1'b0);
		send_item(ACT_ABSORB, '1, 4'd15, 1'b1);
		send_item(ACT_ENC, '1, 4'd8, 1'b0);
		send_item(ACT_ENC, 64'h8000_0000_0000_0001, 4'd1, 1'b1);
		send_item(ACT_DEC, '1, 4'd9, 1'b0);
		send_item(ACT_DEC, 64'hdead_beef, 4'd3, 1'b1);
		send_item(ACT_FIN, '0, 4'd8, 1'b1, 1'b0, '1, '1);
		for (int i = 0; i < 4; i++) t[i] = mdl_state[i];
		// matching tag, then short and wrong tags
		for (int i = 0; i < 4; i++) send_item(ACT_VERIFY, t[i], 4'd8, i == 3);
		send_item(ACT_VERIFY, t[0], 4'd8, 1'b1);
		send_item(ACT_VERIFY, t[0] ^ 64'h1, 4'd8, 1'b0);
		send_item(ACT_VERIFY, t[1], 4'd8, 1'b1);
		send_item(3'd6, '1, 4'd8, 1'b1);
		send_item(3'd7, '1, 4'd8, 1'b0);
		load_iv(1'b1, 10);
	endtask

	task automatic rand_run(int words, logic [2:0] act);
		for (int i = 0; i < words; i++)
			send_item(act, {$urandom, $urandom},
				($urandom_range(3) == 0) ? 4'($urandom) : 4'd8, i == words - 1);
	endtask

	// random AEAD sessions, mostly well-formed
	task automatic test_random_sessions(int count);
		logic [63:0] t [4];
		int n;
		int first;
		first = items_sent;
		while (items_sent < first + count) begin
			if (items_sent - first >= 4 && items_sent - first < 20) no_idle = 1'b1;
			else no_idle = 1'b0;
			if ($urandom_range(9) == 0) begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					send_item(3'($urandom), {$urandom, $urandom}, 4'($urandom),
						1'($urandom), 1'($urandom), {$urandom, $urandom},
						{$urandom, $urandom});
				continue;
			end
			load_iv(1'($urandom), $urandom_range(1, 10));
			rand_run($urandom_range(1, 18), ACT_ABSORB);
			rand_run($urandom_range(1, 14), $urandom_range(1) ? ACT_ENC : ACT_DEC);
			send_item(ACT_FIN, '0, 4'd8, 1'b1, 1'b0, {$urandom, $urandom},
				{$urandom, $urandom});
			for (int i = 0; i < 4; i++) t[i] = mdl_state[i];
			n = $urandom_range(1, 5);
			for (int i = 0; i < n; i++)
				send_item(ACT_VERIFY, ($urandom_range(3) == 0) ? {$urandom, $urandom} :
					t[i & 3], 4'($urandom_range(1, 8)), i == n - 1);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		int drain;
		foreach (mdl_state[i]) mdl_state[i] = '0;
		foreach (mdl_key[i]) mdl_key[i] = '0;
		mdl_pos = '0; mdl_miss = 1'b0; mdl_abs_tag = '0; mdl_enc_tag = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_registers();
		test_directed();
		test_random_sessions(24);
		write_reg(3'd0, {$urandom, $urandom});
		write_reg(REG_ABS_TAG, 64'($urandom_range(255)));
		write_reg(REG_ENC_TAG, 64'hff);
		test_random_sessions(24);
		in_valid <= 1'b0;
		drain = 0;
		while (expected_results.size() != 0 && drain < 100000) begin
			@(negedge clk);
			drain++;
		end
		repeat (4 * PERM_ROUNDS + 8) @(negedge clk);
		$display("ran %0d items through init, absorb, encrypt, decrypt, finalise, verify",
			items_sent);
		$display("checked %0d results over three key and domain tag settings", results_seen);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
